// File: rtl/lsdp_pkg.sv
// Package for the sparkle and decay LED pattern block.
// Holds sizes, register indexes, reset values and the item and config types.
// Depends on nothing; every other file of the block uses it.
package lsdp_pkg;

    // Sizes of the pixel row.
    localparam int PIXEL_COUNT  = 40;
    localparam int LEDS_PER_RAY = 10;
    localparam int RAY_COUNT    = (PIXEL_COUNT + LEDS_PER_RAY - 1) / LEDS_PER_RAY;
    localparam int PIX_W        = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int LED_W        = (LEDS_PER_RAY > 1) ? $clog2(LEDS_PER_RAY) : 1;
    localparam int RAY_W        = (RAY_COUNT > 1) ? $clog2(RAY_COUNT) : 1;
    localparam int SPARK_W      = 6;
    localparam int CMP_W        = (PIX_W > SPARK_W) ? PIX_W : SPARK_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_HUE          = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_SATURATION  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED        = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_ON          = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASS_BOOST_ON     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_TREBLE  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_BASS    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LOW_MID = 4'd7;

    // Register values after reset.
    localparam logic [8:0] RST_BASE_HUE         = 9'd30;
    localparam logic [7:0] RST_COLOR_SATURATION = 8'd255;
    localparam logic [5:0] RST_BASE_SPEED       = 6'd2;

    // Pixel level constants.
    localparam logic [7:0] LEVEL_FULL = 8'd255;

    typedef struct packed {
        logic [5:0]  spark_index;
        logic [15:0] level_treble;
        logic [15:0] level_bass;
        logic [15:0] level_low_mid;
    } t_in_item;

    typedef struct packed {
        logic [1:0] ray_number;
        logic [3:0] led_number;
        logic [8:0] pixel_hue;
        logic [7:0] pixel_saturation;
        logic [7:0] pixel_value;
        logic       last_pixel;
    } t_out_item;

    typedef struct packed {
        logic [8:0]  base_hue;
        logic [7:0]  color_saturation;
        logic [5:0]  base_speed;
        logic        sound_on;
        logic        bass_boost_on;
        logic [15:0] threshold_treble;
        logic [15:0] threshold_bass;
        logic [15:0] threshold_low_mid;
    } t_cfg;

    // Status handed from the speed unit to the sequencer.
    typedef struct packed {
        logic       done;
        logic [5:0] speed;
        logic [8:0] hue;
    } t_speed_status;

endpackage

// File: rtl/lsdp_cell.sv
// One cell of the rotating pixel row: holds the level of one pixel.
// Depends on lsdp_pkg for the full level constant.
module lsdp_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_ignite,
    input  logic       i_shift,
    input  logic [7:0] i_next_level,
    output logic [7:0] o_level
);
    import lsdp_pkg::*;

    logic [7:0] r_level;

    // A spark only lights a dark pixel; while streaming the level moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_ignite && (r_level == '0)) begin
            r_level <= LEVEL_FULL;
        end else if (i_shift) begin
            r_level <= i_next_level;
        end
    end

    assign o_level = r_level;

endmodule

// File: rtl/lsdp_speed.sv
// Works out the hue offset, the wrapped hue and the decay speed of one tick.
// Compare and divide by five are register stages; the cap is combinational. Depends on lsdp_pkg.
module lsdp_speed (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  lsdp_pkg::t_in_item      i_item,
    input  lsdp_pkg::t_cfg          i_cfg,
    output lsdp_pkg::t_speed_status o_status
);
    import lsdp_pkg::*;

    localparam logic [1:0] MODE_BASE   = 2'd0;
    localparam logic [1:0] MODE_BASS   = 2'd1;
    localparam logic [1:0] MODE_LOWMID = 2'd2;

    // Reciprocal of five, exact for 16-bit dividends after a shift by 18.
    localparam logic [32:0] RECIP5 = 33'd52429;

    logic        r_v1;
    logic        r_v2;
    logic [1:0]  r_mode;
    logic [1:0]  r_mode2;
    logic [15:0] r_diff;
    logic [13:0] r_quot;
    logic [8:0]  r_hue_offset;
    logic [8:0]  r_hue;
    logic [5:0]  r_decay_speed;

    logic [1:0]  n_mode;
    logic [15:0] n_diff;
    logic [32:0] w_prod;
    logic [9:0]  w_hue_sum;
    logic [9:0]  w_hue_once;
    logic [9:0]  w_hue_twice;
    logic [13:0] w_cap;
    logic [13:0] w_add;
    logic [6:0]  w_sum;
    logic [5:0]  n_speed;

    // Which band drives the speed, and by how much it exceeds its threshold.
    always_comb begin
        n_mode = MODE_BASE;
        n_diff = i_item.level_low_mid - i_cfg.threshold_low_mid;
        if (i_cfg.sound_on) begin
            if (i_item.level_bass > i_cfg.threshold_bass) begin
                n_mode = MODE_BASS;
                n_diff = i_item.level_bass - i_cfg.threshold_bass;
            end else if (i_cfg.bass_boost_on &&
                         (i_item.level_low_mid > i_cfg.threshold_low_mid)) begin
                n_mode = MODE_LOWMID;
            end
        end
    end

    // Control and state of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_hue_offset  <= '0;
            r_decay_speed <= '0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            if (i_start && i_cfg.sound_on &&
                (i_item.level_treble > i_cfg.threshold_treble)) begin
                r_hue_offset <= (r_hue_offset == 9'd359) ? 9'd0 : r_hue_offset + 9'd1;
            end
            if (r_v2) begin
                r_decay_speed <= n_speed;
            end
        end
    end

    // Stage one: band choice and excess.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mode <= n_mode;
            r_diff <= n_diff;
        end
    end

    // Stage two: divide the excess by five and wrap the hue.
    assign w_prod      = 33'(r_diff) * RECIP5;
    assign w_hue_sum   = 10'(i_cfg.base_hue) + 10'(r_hue_offset);
    assign w_hue_once  = (w_hue_sum >= 10'd360) ? w_hue_sum - 10'd360 : w_hue_sum;
    assign w_hue_twice = (w_hue_once >= 10'd360) ? w_hue_once - 10'd360 : w_hue_once;

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_quot  <= w_prod[31:18];
            r_mode2 <= r_mode;
            r_hue   <= w_hue_twice[8:0];
        end
    end

    // Stage three: cap the step, add it and cap the speed at fifty.
    always_comb begin
        w_cap = (r_mode2 == MODE_BASS && !i_cfg.bass_boost_on) ? 14'd20 : 14'd10;
        w_add = (r_quot > w_cap) ? w_cap : r_quot;
        unique case (r_mode2)
            MODE_BASS:   w_sum = 7'(i_cfg.base_speed) + 7'(w_add);
            MODE_LOWMID: w_sum = 7'(r_decay_speed) + 7'(w_add);
            default:     w_sum = 7'(i_cfg.base_speed);
        endcase
        n_speed = (w_sum > 7'd50) ? 6'd50 : w_sum[5:0];
    end

    assign o_status.done  = r_v2;
    assign o_status.speed = n_speed;
    assign o_status.hue   = r_hue;

endmodule

// File: rtl/lsdp_pixel_map.sv
// Shared unit that decays the head pixel's level and maps it to HSV fields.
// Combinational; depends on lsdp_pkg.
module lsdp_pixel_map (
    input  logic [7:0] i_level,
    input  logic [5:0] i_speed,
    input  logic [8:0] i_hue,
    output logic [7:0] o_level,
    output logic [8:0] o_hue,
    output logic [7:0] o_value
);
    import lsdp_pkg::*;

    // 147 / 1024 gives the floor of a division by seven for values below 128.
    localparam logic [14:0] RECIP7 = 15'd147;

    logic [7:0]  w_level;
    logic [6:0]  w_scalar;
    logic [14:0] w_prod;
    logic [8:0]  w_value;

    // Decay saturating at zero, then fold the level into a triangle.
    always_comb begin
        w_level  = (8'(i_speed) > i_level) ? 8'd0 : i_level - 8'(i_speed);
        w_scalar = (w_level <= 8'd127) ? w_level[6:0] : 7'(LEVEL_FULL - w_level);
        w_prod   = 15'(w_scalar) * RECIP7;
        w_value  = 9'(w_scalar) + 9'd174;
    end

    assign o_level = w_level;
    assign o_hue   = i_hue + 9'(w_prod[14:10]);
    assign o_value = (w_value > 9'd255) ? 8'd255 : w_value[7:0];

endmodule

// File: rtl/led_sparkle_decay_pattern.sv
// Top level of the sparkle and decay LED pattern block.
// Depends on lsdp_pkg, lsdp_cell, lsdp_speed and lsdp_pixel_map.
//
// Usage:
// Each input item is one frame tick: a spark pixel index and three audio band
// levels. It is accepted on i_in_valid and o_in_ready; o_in_ready is high only
// while no tick is being worked on. Each tick gives PIXEL_COUNT result items,
// pixel 0 first, on o_out_valid and i_out_ready; last_pixel marks the final one.
// Configuration is written on i_cfg_valid with o_cfg_ready always high; register
// index i is the i-th register of the list, indexes beyond it are ignored.
// After a tick is taken, the speed unit registers the band choice and excess,
// then the excess divided by five; the sequencer then leaves its calc state
// and the first result is registered. The pace of a tick is set by the row of
// cells, which rotates one pixel a cycle while the receiver does not stall,
// through the single shared decay and colour unit.
// A stalled receiver holds the output register and freezes the row; the next
// tick may be accepted while the last result of a tick still waits.
// Reset clears all pixel levels, the decay speed and the hue offset, and loads
// the register reset values.
module led_sparkle_decay_pattern (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lsdp_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lsdp_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lsdp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsdp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lsdp_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CALC   = 2'd1;
    localparam logic [1:0] ST_STREAM = 2'd2;

    logic [1:0]       r_state;
    t_cfg             r_cfg;
    logic             r_out_valid;
    t_out_item        r_out_item;
    logic [PIX_W-1:0] r_pix;
    logic [LED_W-1:0] r_led;
    logic [RAY_W-1:0] r_ray;
    logic [5:0]       r_speed;
    logic [8:0]       r_hue;

    logic             w_accept;
    logic             w_advance;
    logic             w_last;
    t_speed_status    w_status;
    logic [7:0]       w_level [PIXEL_COUNT];
    logic [7:0]       w_decayed;
    logic [8:0]       w_hue;
    logic [7:0]       w_value;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_advance = (r_state == ST_STREAM) && (!r_out_valid || i_out_ready);
    assign w_last    = (r_pix == PIX_W'(PIXEL_COUNT - 1));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_hue          <= RST_BASE_HUE;
            r_cfg.color_saturation  <= RST_COLOR_SATURATION;
            r_cfg.base_speed        <= RST_BASE_SPEED;
            r_cfg.sound_on          <= 1'b0;
            r_cfg.bass_boost_on     <= 1'b0;
            r_cfg.threshold_treble  <= '0;
            r_cfg.threshold_bass    <= '0;
            r_cfg.threshold_low_mid <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BASE_HUE:          r_cfg.base_hue          <= i_cfg_data[8:0];
                REG_COLOR_SATURATION:  r_cfg.color_saturation  <= i_cfg_data[7:0];
                REG_BASE_SPEED:        r_cfg.base_speed        <= i_cfg_data[5:0];
                REG_SOUND_ON:          r_cfg.sound_on          <= i_cfg_data[0];
                REG_BASS_BOOST_ON:     r_cfg.bass_boost_on     <= i_cfg_data[0];
                REG_THRESHOLD_TREBLE:  r_cfg.threshold_treble  <= i_cfg_data;
                REG_THRESHOLD_BASS:    r_cfg.threshold_bass    <= i_cfg_data;
                REG_THRESHOLD_LOW_MID: r_cfg.threshold_low_mid <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Speed and hue for the tick.
    lsdp_speed u_speed (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .o_status (w_status)
    );

    // Row of cells: cell 0 is the head, the decayed level re-enters at the tail.
    for (genvar k = 0; k < PIXEL_COUNT; k++) begin : g_cell
        logic w_hit;
        logic [7:0] w_next;
        assign w_hit = w_accept &&
                       (CMP_W'(i_in_item.spark_index) == CMP_W'(k));
        if (k == PIXEL_COUNT - 1) begin : g_tail
            assign w_next = w_decayed;
        end else begin : g_body
            assign w_next = w_level[k+1];
        end
        lsdp_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ignite     (w_hit),
            .i_shift      (w_advance),
            .i_next_level (w_next),
            .o_level      (w_level[k])
        );
    end

    lsdp_pixel_map u_map (
        .i_level (w_level[0]),
        .i_speed (r_speed),
        .i_hue   (r_hue),
        .o_level (w_decayed),
        .o_hue   (w_hue),
        .o_value (w_value)
    );

    // Sequencer and pixel position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pix   <= '0;
            r_led   <= '0;
            r_ray   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    if (w_status.done) begin
                        r_state <= ST_STREAM;
                    end
                end
                ST_STREAM: begin
                    if (w_advance) begin
                        if (w_last) begin
                            r_state <= ST_IDLE;
                            r_pix   <= '0;
                            r_led   <= '0;
                            r_ray   <= '0;
                        end else begin
                            r_pix <= r_pix + PIX_W'(1);
                            if (r_led == LED_W'(LEDS_PER_RAY - 1)) begin
                                r_led <= '0;
                                r_ray <= r_ray + RAY_W'(1);
                            end else begin
                                r_led <= r_led + LED_W'(1);
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Speed and hue are held for the whole stream of the tick.
    always_ff @(posedge i_clk) begin
        if (w_status.done) begin
            r_speed <= w_status.speed;
            r_hue   <= w_status.hue;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item.ray_number       <= 2'(r_ray);
            r_out_item.led_number       <= 4'(r_led);
            r_out_item.pixel_hue        <= w_hue;
            r_out_item.pixel_saturation <= r_cfg.color_saturation;
            r_out_item.pixel_value      <= w_value;
            r_out_item.last_pixel       <= w_last;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: rtl/lsdp_checker.sv
// Port checker for the sparkle and decay LED pattern block, bound to the top.
// Depends on lsdp_pkg for the item types and on the top level's ports.
module lsdp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input lsdp_pkg::t_out_item             o_out_item
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // A taken tick closes the input; the design keeps it closed until its last pixel is registered.
    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second tick taken while busy");

    // A pixel other than the last one means a tick is still streaming.
    a_busy_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last_pixel |-> !o_in_ready)
        else $error("input open in the middle of a tick");

endmodule

bind led_sparkle_decay_pattern lsdp_checker u_lsdp_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_sparkle_decay_pattern: directed and random frame ticks.
// A scoreboard class predicts the forty HSV pixel items of every tick and checks them in order.
// Depends on lsdp_pkg and the RTL of the block only.
module tb_top;
    import lsdp_pkg::*;

    // Prediction of the pixel row, plus the queue of pixel items still to arrive.
    class sparkle_board;
        t_cfg       regs;
        logic [7:0] levels [PIXEL_COUNT];
        logic [5:0] speed;
        logic [8:0] hue_offset;
        t_out_item  pixel_queue [$];
        int         errors;
        int         ticks;
        int         pixels_seen;

        function new();
            regs = '0;
            regs.base_hue = RST_BASE_HUE;
            regs.color_saturation = RST_COLOR_SATURATION;
            regs.base_speed = RST_BASE_SPEED;
            foreach (levels[p]) levels[p] = '0;
            speed = '0;
            hue_offset = '0;
            errors = 0;
            ticks = 0;
            pixels_seen = 0;
        endfunction

        function int pending();
            return pixel_queue.size();
        endfunction

        // Mirror of a register write; unknown indexes are dropped as the block does.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BASE_HUE:          regs.base_hue = data[8:0];
                REG_COLOR_SATURATION:  regs.color_saturation = data[7:0];
                REG_BASE_SPEED:        regs.base_speed = data[5:0];
                REG_SOUND_ON:          regs.sound_on = data[0];
                REG_BASS_BOOST_ON:     regs.bass_boost_on = data[0];
                REG_THRESHOLD_TREBLE:  regs.threshold_treble = data;
                REG_THRESHOLD_BASS:    regs.threshold_bass = data;
                REG_THRESHOLD_LOW_MID: regs.threshold_low_mid = data;
                default: ;
            endcase
        endfunction

        // Ignite, update hue and speed, decay the row and queue forty pixel items.
        function void take_tick(t_in_item it);
            int unsigned spd;
            int unsigned excess;
            int unsigned cap;
            int unsigned lvl;
            int unsigned scalar;
            int unsigned val;
            int unsigned hue;
            t_out_item   px;

            ticks++;
            if (it.spark_index < PIXEL_COUNT && levels[it.spark_index] == 8'd0)
                levels[it.spark_index] = LEVEL_FULL;

            if (regs.sound_on && it.level_treble > regs.threshold_treble)
                hue_offset = 9'((hue_offset + 1) % 360);

            spd = speed;
            if (regs.sound_on) begin
                if (it.level_bass > regs.threshold_bass) begin
                    cap = regs.bass_boost_on ? 10 : 20;
                    excess = (32'(it.level_bass) - 32'(regs.threshold_bass)) / 5;
                    spd = regs.base_speed + ((excess > cap) ? cap : excess);
                end else if (regs.bass_boost_on && it.level_low_mid > regs.threshold_low_mid) begin
                    excess = (32'(it.level_low_mid) - 32'(regs.threshold_low_mid)) / 5;
                    spd = spd + ((excess > 10) ? 10 : excess);
                end else begin
                    spd = regs.base_speed;
                end
            end else begin
                spd = regs.base_speed;
            end
            if (spd > 50)
                spd = 50;
            speed = spd[5:0];

            hue = (32'(regs.base_hue) + 32'(hue_offset)) % 360;

            for (int p = 0; p < PIXEL_COUNT; p++) begin
                lvl = levels[p];
                if (lvl != 0)
                    lvl = (spd > lvl) ? 0 : lvl - spd;
                levels[p] = lvl[7:0];
                scalar = (lvl <= 127) ? lvl : 255 - lvl;
                val = scalar + 174;
                if (val > 255)
                    val = 255;
                px.ray_number = 2'(p / LEDS_PER_RAY);
                px.led_number = 4'(p % LEDS_PER_RAY);
                px.pixel_hue = 9'(hue + scalar / 7);
                px.pixel_saturation = regs.color_saturation;
                px.pixel_value = val[7:0];
                px.last_pixel = (p == PIXEL_COUNT - 1);
                pixel_queue.push_back(px);
            end
        endfunction

        // One line per mismatch, and each one is counted.
        task report(string what, int unsigned got, int unsigned want);
            errors++;
            $display("MISMATCH %s at pixel item %0d: got %0d, want %0d",
                     what, pixels_seen, got, want);
        endtask

        task check_pixel(t_out_item got);
            t_out_item want;

            pixels_seen++;
            if (pixel_queue.size() == 0) begin
                report("pixel item with no tick waiting", got, 0);
                return;
            end
            want = pixel_queue.pop_front();
            if (got.ray_number != want.ray_number)
                report("ray_number", got.ray_number, want.ray_number);
            if (got.led_number != want.led_number)
                report("led_number", got.led_number, want.led_number);
            if (got.pixel_hue != want.pixel_hue)
                report("pixel_hue", got.pixel_hue, want.pixel_hue);
            if (got.pixel_saturation != want.pixel_saturation)
                report("pixel_saturation", got.pixel_saturation, want.pixel_saturation);
            if (got.pixel_value != want.pixel_value)
                report("pixel_value", got.pixel_value, want.pixel_value);
            if (got.last_pixel != want.last_pixel)
                report("last_pixel", got.last_pixel, want.last_pixel);
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              in_item = '0;
    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    bit                    steady = 1'b0;
    sparkle_board          board;

    led_sparkle_decay_pattern u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Choose an idle gap with a chance of about 18 in a hundred, except during the steady stretch.
    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < 18);
    endfunction

    // Receiver: check each accepted pixel item, then choose the next ready.
    always @(posedge clk) begin
        if (rst_n) begin
            if (o_out_valid && out_ready)
                board.check_pixel(o_out_item);
            out_ready <= !take_gap();
        end
    end

    // Offer one tick and hold it until the block takes it; valid stays high afterwards.
    task automatic send_tick(t_in_item it);
        if (take_gap()) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 45)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!o_in_ready);
        board.take_tick(it);
    endtask

    task automatic tick(int spark, int treble, int bass, int low_mid);
        t_in_item it;

        it.spark_index = 6'(spark);
        it.level_treble = 16'(treble);
        it.level_bass = 16'(bass);
        it.level_low_mid = 16'(low_mid);
        send_tick(it);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
    endtask

    // Stop offering ticks and wait until every pixel item has come back.
    task automatic drain();
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [15:0] cfg_value(int lo, int hi);
        case ($urandom_range(4))
            0: return 16'(lo);
            1: return 16'(hi);
            2: return 16'($urandom);
            default: return 16'($urandom_range(hi, lo));
        endcase
    endfunction

    // Band levels clustered around the threshold so that both sides of it are hit.
    function automatic logic [15:0] band_level(logic [15:0] thr);
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(thr + $urandom_range(0, 120));
            3: return 16'(thr - $urandom_range(0, 20));
            4: return 16'($urandom);
            default: return 16'(thr + $urandom_range(1, 8));
        endcase
    endfunction

    task automatic random_setup();
        write_register(REG_BASE_HUE, cfg_value(0, 359));
        write_register(REG_COLOR_SATURATION, cfg_value(0, 255));
        write_register(REG_BASE_SPEED,
                       ($urandom_range(3) == 0) ? cfg_value(0, 50) : 16'($urandom_range(6)));
        write_register(REG_SOUND_ON, {15'($urandom), 1'($urandom_range(3) != 0)});
        write_register(REG_BASS_BOOST_ON, 16'($urandom));
        write_register(REG_THRESHOLD_TREBLE, cfg_value(0, 65535));
        write_register(REG_THRESHOLD_BASS, cfg_value(0, 65535));
        write_register(REG_THRESHOLD_LOW_MID, cfg_value(0, 65535));
        if ($urandom_range(3) == 0)
            write_register(REG_THRESHOLD_LOW_MID + 4'($urandom_range(1, 8)), 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_ticks(int count);
        t_in_item it;

        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 85)
                it.spark_index = 6'($urandom_range(PIXEL_COUNT - 1));
            else
                it.spark_index = 6'($urandom_range(63, PIXEL_COUNT));
            it.level_treble = band_level(board.regs.threshold_treble);
            it.level_bass = band_level(board.regs.threshold_bass);
            it.level_low_mid = band_level(board.regs.threshold_low_mid);
            send_tick(it);
        end
    endtask

    // Main sequence: reset, directed ticks under fixed settings, then random phases.
    initial begin
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, sound off: edge pixels, out-of-range sparks, a spark on a pixel that is still lit.
        tick(0, 0, 0, 0);
        tick(PIXEL_COUNT - 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        tick(PIXEL_COUNT, 0, 0, 0);
        tick(63, 16'hFFFF, 0, 16'hFFFF);
        tick(0, 0, 0, 0);
        tick(32, 0, 0, 0);
        drain();

        // Sound on without bass boost: treble at and above threshold, bass cap of 20.
        write_register(REG_BASE_HUE, 16'd359);
        write_register(REG_COLOR_SATURATION, 16'd0);
        write_register(REG_BASE_SPEED, 16'd0);
        write_register(REG_SOUND_ON, 16'd1);
        write_register(REG_BASS_BOOST_ON, 16'd0);
        write_register(REG_THRESHOLD_TREBLE, 16'd100);
        write_register(REG_THRESHOLD_BASS, 16'd1000);
        write_register(REG_THRESHOLD_LOW_MID, 16'd0);
        cfg_valid <= 1'b0;
        tick(5, 101, 1000, 0);
        tick(6, 100, 1125, 16'hFFFF);
        tick(7, 16'hFFFF, 1001, 0);
        tick(8, 0, 16'hFFFF, 0);
        drain();

        // Base hue and base speed beyond their ranges, bass boost, ignored indexes.
        write_register(REG_BASE_HUE, 16'hFFFF);
        write_register(REG_COLOR_SATURATION, 16'hFFFF);
        write_register(REG_BASE_SPEED, 16'hFFFF);
        write_register(REG_BASS_BOOST_ON, 16'd1);
        write_register(REG_THRESHOLD_TREBLE, 16'd0);
        write_register(REG_THRESHOLD_BASS, 16'hFFFF);
        write_register(REG_THRESHOLD_LOW_MID + 4'd1, 16'h0000);
        write_register(REG_THRESHOLD_LOW_MID + 4'd8, 16'h1234);
        cfg_valid <= 1'b0;
        tick(9, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        tick(10, 1, 16'hFFFF, 0);
        drain();

        // Bass cap of 10, then the low-mid path adding to the running speed.
        write_register(REG_BASE_HUE, 16'd0);
        write_register(REG_BASE_SPEED, 16'd1);
        write_register(REG_THRESHOLD_BASS, 16'd0);
        cfg_valid <= 1'b0;
        tick(11, 0, 60, 0);
        tick(12, 0, 0, 15);
        tick(13, 0, 0, 50);
        tick(20, 0, 0, 0);
        tick(21, 0, 0, 0);
        tick(22, 0, 0, 0);
        drain();

        // Random phases, each with fresh settings; two of them run without idling.
        for (int ph = 0; ph < 8; ph++) begin
            steady = (ph == 3 || ph == 4);
            random_setup();
            random_ticks(25);
            drain();
        end
        steady = 1'b0;

        repeat (10) @(posedge clk);
        $display("Covered %0d ticks and %0d pixel items over 4 directed and 8 random settings.",
                 board.ticks, board.pixels_seen);
        $display("Mismatches counted: %0d", board.errors);
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
